// ===== src/toe_pkg.sv =====
// ----------------------------------------------------------------------------
// toe_pkg
// Shared sizes, payload types and controller/datapath handshake structs for
// the topological order engine.
// ----------------------------------------------------------------------------
package toe_pkg;

    // Storage sizes.
    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;

    // Field widths fixed by the item format.
    localparam int NODE_W = 6;
    localparam int CNT_W  = 7;

    // Derived widths.
    localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EDGE_CW = $clog2(MAX_EDGES + 1);
    localparam int DEG_W   = EDGE_CW;
    localparam int QPTR_W  = $clog2(MAX_NODES + 1);
    localparam int IDX_W   = (EDGE_CW > CNT_W) ? EDGE_CW : CNT_W;

    // Configuration register map (word index) and reset value.
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(64);

    // Input item: an edge load or a run request.
    typedef struct packed {
        logic              action;
        logic [NODE_W-1:0] edge_source;
        logic [NODE_W-1:0] edge_target;
    } t_in_item;

    // Action codes.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_RUN  = 1'b1;

    // Result item: one ordered node.
    typedef struct packed {
        logic [NODE_W-1:0] node_index;
        logic              node_valid;
        logic              last;
        logic              cycle_found;
        logic              edge_overflow;
    } t_out_item;

    // One stored edge.
    typedef struct packed {
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
    } t_edge;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic edge_wr;      // store the accepted edge
        logic edge_rd;      // read the edge at the index counter
        logic idx_clr;
        logic idx_inc;
        logic deg_clr_wr;   // zero the in-degree at the index counter
        logic deg_rd_tgt;   // read the in-degree of the fetched edge's target
        logic deg_rd_idx;   // read the in-degree at the index counter
        logic deg_inc_wr;
        logic deg_dec_wr;
        logic q_push_idx;   // enqueue the index counter
        logic q_push_tgt;   // enqueue the latched target
        logic q_rd;         // read the queue head
        logic ptr_clr;
        logic node_take;    // latch the head entry and advance the head
        logic emit_node;
        logic emit_none;
        logic store_clr;    // empty the edge store after a run
    } t_toe_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_at_edges;
        logic idx_at_nodes;
        logic idx_at_clr_end;
        logic cnt_hit;
        logic scan_hit;
        logic deg_zero;
        logic deg_one;
        logic queue_empty;
        logic out_free;
    } t_toe_sts;

endpackage

// ===== src/toe_datapath.sv =====
// ----------------------------------------------------------------------------
// toe_datapath
// Edge store, in-degree table, ready queue, counters, configuration register
// and the result register of the topological order engine.
// ----------------------------------------------------------------------------
module toe_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  toe_pkg::t_toe_cmd         i_cmd,
    output toe_pkg::t_toe_sts         o_sts,
    input  toe_pkg::t_in_item         i_in_data,
    input  logic                      i_cfg_we,
    input  logic [toe_pkg::CNT_W-1:0] i_cfg_data,
    output logic [toe_pkg::CNT_W-1:0] o_node_count,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output toe_pkg::t_out_item        o_out_data
);

    // Memories.
    toe_pkg::t_edge                   mem_edge [toe_pkg::MAX_EDGES];
    logic [toe_pkg::DEG_W-1:0]        mem_deg  [toe_pkg::MAX_NODES];
    logic [toe_pkg::NODE_W-1:0]       mem_q    [toe_pkg::MAX_NODES];

    // Registers and their next values.
    logic [toe_pkg::CNT_W-1:0]   r_node_count, n_node_count;
    logic [toe_pkg::EDGE_CW-1:0] r_edge_cnt, n_edge_cnt;
    logic                        r_ovf, n_ovf;
    logic [toe_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [toe_pkg::QPTR_W-1:0]  r_head, n_head;
    logic [toe_pkg::QPTR_W-1:0]  r_tail, n_tail;
    logic [toe_pkg::NODE_W-1:0]  r_node, n_node;
    logic [toe_pkg::NODE_W-1:0]  r_tgt, n_tgt;
    logic                        r_out_valid, n_out_valid;
    toe_pkg::t_out_item          r_out, n_out;
    toe_pkg::t_edge              r_edge_rd;
    logic [toe_pkg::DEG_W-1:0]   r_deg_rd;
    logic [toe_pkg::NODE_W-1:0]  r_q_rd;

    // Combinational helpers.
    logic [toe_pkg::CNT_W-1:0]   w_n;
    logic                        w_full;
    logic                        w_out_free;
    logic                        w_last;
    logic                        w_deg_we;
    logic [toe_pkg::NODE_AW-1:0] w_deg_waddr;
    logic [toe_pkg::DEG_W-1:0]   w_deg_wdata;
    logic                        w_deg_re;
    logic [toe_pkg::NODE_AW-1:0] w_deg_raddr;
    logic                        w_q_push;
    logic [toe_pkg::NODE_W-1:0]  w_q_wdata;
    logic                        w_cyc;

    // Node count in effect, capped at the table size.
    assign w_n = (r_node_count > toe_pkg::CNT_W'(toe_pkg::MAX_NODES))
                 ? toe_pkg::CNT_W'(toe_pkg::MAX_NODES) : r_node_count;
    assign w_full     = (r_edge_cnt == toe_pkg::EDGE_CW'(toe_pkg::MAX_EDGES));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last     = (r_head == r_tail);
    assign w_cyc      = (toe_pkg::CNT_W'(r_head) < w_n);

    // In-degree table port selection.
    always_comb begin
        w_deg_we    = i_cmd.deg_clr_wr || i_cmd.deg_inc_wr || i_cmd.deg_dec_wr;
        w_deg_waddr = r_tgt[toe_pkg::NODE_AW-1:0];
        w_deg_wdata = r_deg_rd + toe_pkg::DEG_W'(1);
        if (i_cmd.deg_clr_wr) begin
            w_deg_waddr = r_idx[toe_pkg::NODE_AW-1:0];
            w_deg_wdata = '0;
        end else if (i_cmd.deg_dec_wr) begin
            w_deg_wdata = r_deg_rd - toe_pkg::DEG_W'(1);
        end
        w_deg_re    = i_cmd.deg_rd_tgt || i_cmd.deg_rd_idx;
        w_deg_raddr = i_cmd.deg_rd_idx ? r_idx[toe_pkg::NODE_AW-1:0]
                                       : r_edge_rd.to_node[toe_pkg::NODE_AW-1:0];
    end

    // Ready queue write selection.
    assign w_q_push  = i_cmd.q_push_idx || i_cmd.q_push_tgt;
    assign w_q_wdata = i_cmd.q_push_idx ? r_idx[toe_pkg::NODE_W-1:0] : r_tgt;

    // Memory ports; read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_wr && !w_full) begin
            mem_edge[r_edge_cnt[toe_pkg::EDGE_AW-1:0]] <=
                '{from_node: i_in_data.edge_source, to_node: i_in_data.edge_target};
        end
        if (i_cmd.edge_rd) begin
            r_edge_rd <= mem_edge[r_idx[toe_pkg::EDGE_AW-1:0]];
        end
        if (w_deg_we) begin
            mem_deg[w_deg_waddr] <= w_deg_wdata;
        end
        if (w_deg_re) begin
            r_deg_rd <= mem_deg[w_deg_raddr];
        end
        if (w_q_push) begin
            mem_q[r_tail[toe_pkg::NODE_AW-1:0]] <= w_q_wdata;
        end
        if (i_cmd.q_rd) begin
            r_q_rd <= mem_q[r_head[toe_pkg::NODE_AW-1:0]];
        end
    end

    // Next-value logic for counters, pointers and the result register.
    always_comb begin
        n_node_count = r_node_count;
        n_edge_cnt   = r_edge_cnt;
        n_ovf        = r_ovf;
        n_idx        = r_idx;
        n_head       = r_head;
        n_tail       = r_tail;
        n_node       = r_node;
        n_tgt        = r_tgt;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;

        if (i_cfg_we) begin
            n_node_count = i_cfg_data;
        end

        // Edge loads fill the store until it is full, then flag the loss.
        if (i_cmd.edge_wr) begin
            if (w_full) begin
                n_ovf = 1'b1;
            end else begin
                n_edge_cnt = r_edge_cnt + toe_pkg::EDGE_CW'(1);
            end
        end
        if (i_cmd.store_clr) begin
            n_edge_cnt = '0;
            n_ovf      = 1'b0;
        end

        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + toe_pkg::IDX_W'(1);
        end

        if (i_cmd.deg_rd_tgt) begin
            n_tgt = r_edge_rd.to_node;
        end

        if (i_cmd.ptr_clr) begin
            n_head = '0;
            n_tail = '0;
        end else begin
            if (w_q_push) begin
                n_tail = r_tail + toe_pkg::QPTR_W'(1);
            end
            if (i_cmd.node_take) begin
                n_head = r_head + toe_pkg::QPTR_W'(1);
                n_node = r_q_rd;
            end
        end

        // Result formation; flags ride only on the final result.
        if (i_cmd.emit_node) begin
            n_out_valid         = 1'b1;
            n_out.node_index    = r_node;
            n_out.node_valid    = 1'b1;
            n_out.last          = w_last;
            n_out.cycle_found   = w_last && w_cyc;
            n_out.edge_overflow = w_last && r_ovf;
        end else if (i_cmd.emit_none) begin
            n_out_valid         = 1'b1;
            n_out.node_index    = '0;
            n_out.node_valid    = 1'b0;
            n_out.last          = 1'b1;
            n_out.cycle_found   = w_cyc;
            n_out.edge_overflow = r_ovf;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= toe_pkg::NODE_COUNT_RST;
            r_edge_cnt   <= '0;
            r_ovf        <= 1'b0;
            r_idx        <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_node_count <= n_node_count;
            r_edge_cnt   <= n_edge_cnt;
            r_ovf        <= n_ovf;
            r_idx        <= n_idx;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_tgt  <= n_tgt;
        r_out  <= n_out;
    end

    // Status toward the controller.
    always_comb begin
        o_sts.idx_at_edges   = (r_idx == toe_pkg::IDX_W'(r_edge_cnt));
        o_sts.idx_at_nodes   = (r_idx == toe_pkg::IDX_W'(w_n));
        o_sts.idx_at_clr_end = (r_idx == toe_pkg::IDX_W'(toe_pkg::MAX_NODES - 1));
        o_sts.cnt_hit        = (toe_pkg::CNT_W'(r_edge_rd.from_node) < w_n) &&
                               (toe_pkg::CNT_W'(r_edge_rd.to_node) < w_n);
        o_sts.scan_hit       = (r_edge_rd.from_node == r_node) &&
                               (toe_pkg::CNT_W'(r_edge_rd.to_node) < w_n);
        o_sts.deg_zero       = (r_deg_rd == '0);
        o_sts.deg_one        = (r_deg_rd == toe_pkg::DEG_W'(1));
        o_sts.queue_empty    = w_last;
        o_sts.out_free       = w_out_free;
    end

    assign o_node_count = r_node_count;
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

endmodule

// ===== src/toe_ctrl.sv =====
// ----------------------------------------------------------------------------
// toe_ctrl
// Sequencer of the topological order engine: clears and counts in-degrees,
// seeds the ready queue, then walks the edge store once per dequeued node.
// ----------------------------------------------------------------------------
module toe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_action,
    output logic              o_in_stall,
    input  toe_pkg::t_toe_sts i_sts,
    output toe_pkg::t_toe_cmd o_cmd
);

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_CLR       = 15'b000000000000010,
        S_CNT_RD    = 15'b000000000000100,
        S_CNT_EDGE  = 15'b000000000001000,
        S_CNT_INC   = 15'b000000000010000,
        S_Z_RD      = 15'b000000000100000,
        S_Z_CHK     = 15'b000000001000000,
        S_DEQ       = 15'b000000010000000,
        S_DEQ_WAIT  = 15'b000000100000000,
        S_SC_RD     = 15'b000001000000000,
        S_SC_EDGE   = 15'b000010000000000,
        S_SC_DEC    = 15'b000100000000000,
        S_EMIT      = 15'b001000000000000,
        S_EMIT_NONE = 15'b010000000000000,
        S_DONE      = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            // Edge loads complete in the transfer cycle; a run starts the sweep.
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_action == toe_pkg::ACT_RUN) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_CLR;
                    end else begin
                        o_cmd.edge_wr = 1'b1;
                    end
                end
            end
            // Zero every in-degree entry, one per cycle.
            S_CLR: begin
                o_cmd.deg_clr_wr = 1'b1;
                if (i_sts.idx_at_clr_end) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_CNT_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            // Count in-degrees over the stored edges.
            S_CNT_RD: begin
                if (i_sts.idx_at_edges) begin
                    o_cmd.idx_clr = 1'b1;
                    o_cmd.ptr_clr = 1'b1;
                    n_state       = S_Z_RD;
                end else begin
                    o_cmd.edge_rd = 1'b1;
                    n_state       = S_CNT_EDGE;
                end
            end
            S_CNT_EDGE: begin
                if (i_sts.cnt_hit) begin
                    o_cmd.deg_rd_tgt = 1'b1;
                    n_state          = S_CNT_INC;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_CNT_RD;
                end
            end
            S_CNT_INC: begin
                o_cmd.deg_inc_wr = 1'b1;
                o_cmd.idx_inc    = 1'b1;
                n_state          = S_CNT_RD;
            end
            // Seed the queue with zero in-degree nodes in ascending order.
            S_Z_RD: begin
                if (i_sts.idx_at_nodes) begin
                    n_state = S_DEQ;
                end else begin
                    o_cmd.deg_rd_idx = 1'b1;
                    n_state          = S_Z_CHK;
                end
            end
            S_Z_CHK: begin
                o_cmd.q_push_idx = i_sts.deg_zero;
                o_cmd.idx_inc    = 1'b1;
                n_state          = S_Z_RD;
            end
            // Take the next ready node, or report an empty order.
            S_DEQ: begin
                if (i_sts.queue_empty) begin
                    n_state = S_EMIT_NONE;
                end else begin
                    o_cmd.q_rd = 1'b1;
                    n_state    = S_DEQ_WAIT;
                end
            end
            S_DEQ_WAIT: begin
                o_cmd.node_take = 1'b1;
                o_cmd.idx_clr   = 1'b1;
                n_state         = S_SC_RD;
            end
            // Walk the edges of the current node in load order.
            S_SC_RD: begin
                if (i_sts.idx_at_edges) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.edge_rd = 1'b1;
                    n_state       = S_SC_EDGE;
                end
            end
            S_SC_EDGE: begin
                if (i_sts.scan_hit) begin
                    o_cmd.deg_rd_tgt = 1'b1;
                    n_state          = S_SC_DEC;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SC_RD;
                end
            end
            S_SC_DEC: begin
                o_cmd.deg_dec_wr = !i_sts.deg_zero;
                o_cmd.q_push_tgt = i_sts.deg_one;
                o_cmd.idx_inc    = 1'b1;
                n_state          = S_SC_RD;
            end
            // Hand the node to the result register once it is free.
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_node = 1'b1;
                    n_state         = i_sts.queue_empty ? S_DONE : S_DEQ;
                end
            end
            S_EMIT_NONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_none = 1'b1;
                    n_state         = S_DONE;
                end
            end
            // Empty the edge store for the next graph.
            S_DONE: begin
                o_cmd.store_clr = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/topological_order_engine_unit.sv =====
// Edge load: one transfer per cycle with no result; the edge is stored at the transfer.
// Run: clears every in-degree entry, counts in-degrees over the stored edges and seeds
// the queue with zero in-degree nodes; each dequeued node then walks every stored edge,
// and a result waits while the output is stalled. The edge store has a single read port,
// and the input stalls until the run has finished.
// Reset (synchronous, active low) empties the edge store, clears overflow, sets node_count 64.
// ----------------------------------------------------------------------------
// topological_order_engine_unit
// Kahn topological sort over a loaded edge store, with an APB register for
// the node count and valid/stall item channels.
// ----------------------------------------------------------------------------
module topological_order_engine_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  toe_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output toe_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    toe_pkg::t_toe_cmd         w_cmd;
    toe_pkg::t_toe_sts         w_sts;
    logic                      w_cfg_we;
    logic [toe_pkg::CNT_W-1:0] w_node_count;

    // Register access decode; the port never inserts wait states.
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready &&
                      (paddr[2] == toe_pkg::REG_NODE_COUNT);
    assign prdata   = (paddr[2] == toe_pkg::REG_NODE_COUNT)
                      ? {{(32 - toe_pkg::CNT_W){1'b0}}, w_node_count} : '0;

    toe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in_data.action),
        .o_in_stall  (o_in_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    toe_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_in_data    (i_in_data),
        .i_cfg_we     (w_cfg_we),
        .i_cfg_data   (pwdata[toe_pkg::CNT_W-1:0]),
        .o_node_count (w_node_count),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

// ===== src/toe_checker.sv =====
// ----------------------------------------------------------------------------
// toe_checker
// Port-level checks of the topological order engine, bound to the top level.
// ----------------------------------------------------------------------------
module toe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input toe_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input toe_pkg::t_out_item o_out_data
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // An accepted run item occupies the engine in the next cycle.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.action == toe_pkg::ACT_RUN)
        |=> o_in_stall)
        else $error("run transfer did not start the sort");

    // An edge load leaves the engine ready for the next item.
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.action == toe_pkg::ACT_LOAD)
        |=> !o_in_stall)
        else $error("edge load stalled the input");

    // An empty result only closes a run.
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.node_valid || o_out_data.last)
        else $error("empty result without last");

    // Cycle and overflow flags appear on the final result only.
    a_flags_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last
        |-> !o_out_data.cycle_found && !o_out_data.edge_overflow)
        else $error("status flag before the final result");

endmodule

bind topological_order_engine_unit toe_checker u_toe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== tb/sv/tb_topological_order_engine_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_topological_order_engine_unit
// Self-checking bench for the topological order engine. Edge loads and sort
// runs are sent over the input channel, the node count is set through the
// APB port, and every ordered node is compared with a Kahn sort kept in the
// bench. A short directed table covers empty, looped, oversized and minimal
// graphs. A full edge store with overflow follows, then random graphs, mostly
// acyclic with random content, some with cycles or out-of-range nodes.
// ----------------------------------------------------------------------------
module tb_topological_order_engine_unit;

    localparam int unsigned RAND_ITEMS      = 70;
    localparam int unsigned MAX_IDLE        = 17;
    localparam int unsigned POST_RUN_CYCLES = 2 * toe_pkg::MAX_NODES;
    localparam int unsigned RUN_LIMIT_NS    = 5_000_000;
    localparam logic [2:0]  NODE_COUNT_ADDR = {toe_pkg::REG_NODE_COUNT, 2'b00};

    // Results whose value is plain from the graph alone.
    localparam toe_pkg::t_out_item NO_RESULT = '0;
    localparam toe_pkg::t_out_item EMPTY_RUN = '{6'd0, 1'b0, 1'b1, 1'b0, 1'b0};
    localparam toe_pkg::t_out_item LOOP_RUN  = '{6'd0, 1'b0, 1'b1, 1'b1, 1'b0};
    localparam toe_pkg::t_out_item LONE_NODE = '{6'd0, 1'b1, 1'b1, 1'b0, 1'b0};

    typedef enum {SHAPE_DAG, SHAPE_NOISE, SHAPE_LOOP, SHAPE_BARE} t_shape;

    // One row of the directed table; res is used only when typed is set.
    typedef struct packed {
        logic                       set_cnt;
        logic [toe_pkg::CNT_W-1:0]  cnt;
        logic                       action;
        logic [toe_pkg::NODE_W-1:0] src;
        logic [toe_pkg::NODE_W-1:0] tgt;
        logic                       typed;
        toe_pkg::t_out_item         res;
    } t_dir_row;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    toe_pkg::t_in_item  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    toe_pkg::t_out_item out_data;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [2:0]         paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Bench copy of the engine state.
    toe_pkg::t_edge            edge_mem [toe_pkg::MAX_EDGES];
    int unsigned               edges_held    = 0;
    logic                      overflow_held = 1'b0;
    logic [toe_pkg::CNT_W-1:0] node_cnt      = toe_pkg::NODE_COUNT_RST;

    // Orders predicted for accepted runs, oldest first.
    toe_pkg::t_out_item order_expect_q [$];
    toe_pkg::t_out_item run_order [$];

    bit          calm            = 1'b0;
    int unsigned mismatches      = 0;
    int unsigned items_sent      = 0;
    int unsigned loads_sent      = 0;
    int unsigned runs_sent       = 0;
    int unsigned results_checked = 0;
    int unsigned cfg_writes      = 0;

    t_dir_row directed_rows [21] = '{
        '{1'b0, 7'd0,   toe_pkg::ACT_RUN,  6'd0,  6'd0,  1'b0, NO_RESULT},
        '{1'b1, 7'd0,   toe_pkg::ACT_LOAD, 6'd0,  6'd1,  1'b0, NO_RESULT},
        '{1'b0, 7'd0,   toe_pkg::ACT_RUN,  6'd0,  6'd0,  1'b1, EMPTY_RUN},
        '{1'b1, 7'd1,   toe_pkg::ACT_LOAD, 6'd0,  6'd0,  1'b0, NO_RESULT},
        '{1'b0, 7'd0,   toe_pkg::ACT_RUN,  6'd0,  6'd0,  1'b1, LOOP_RUN},
        '{1'b1, 7'd4,   toe_pkg::ACT_LOAD, 6'd3,  6'd2,  1'b0, NO_RESULT},
        '{1'b0, 7'd0,   toe_pkg::ACT_LOAD, 6'd2,  6'd1,  1'b0, NO_RESULT},
        '{1'b0, 7'd0,   toe_pkg::ACT_LOAD, 6'd1,  6'd0,  1'b0, NO_RESULT},
        '{1'b0, 7'd0,   toe_pkg::ACT_LOAD, 6'd3,  6'd0,  1'b0, NO_RESULT},
        '{1'b0, 7'd0,   toe_pkg::ACT_LOAD, 6'd3,  6'd0,  1'b0, NO_RESULT},
        '{1'b0, 7'd0,   toe_pkg::ACT_LOAD, 6'd63, 6'd1,  1'b0, NO_RESULT},
        '{1'b0, 7'd0,   toe_pkg::ACT_RUN,  6'd0,  6'd0,  1'b0, NO_RESULT},
        '{1'b1, 7'd127, toe_pkg::ACT_LOAD, 6'd63, 6'd0,  1'b0, NO_RESULT},
        '{1'b0, 7'd0,   toe_pkg::ACT_LOAD, 6'd0,  6'd63, 1'b0, NO_RESULT},
        '{1'b0, 7'd0,   toe_pkg::ACT_RUN,  6'd0,  6'd0,  1'b0, NO_RESULT},
        '{1'b1, 7'd64,  toe_pkg::ACT_LOAD, 6'd62, 6'd63, 1'b0, NO_RESULT},
        '{1'b0, 7'd0,   toe_pkg::ACT_LOAD, 6'd63, 6'd0,  1'b0, NO_RESULT},
        '{1'b0, 7'd0,   toe_pkg::ACT_RUN,  6'd0,  6'd0,  1'b0, NO_RESULT},
        '{1'b1, 7'd1,   toe_pkg::ACT_RUN,  6'd0,  6'd0,  1'b1, LONE_NODE},
        '{1'b1, 7'd2,   toe_pkg::ACT_LOAD, 6'd1,  6'd0,  1'b0, NO_RESULT},
        '{1'b0, 7'd0,   toe_pkg::ACT_RUN,  6'd63, 6'd63, 1'b0, NO_RESULT}
    };

    topological_order_engine_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Free-running clock, 2 ns period.
    initial begin
        forever #1 clk = ~clk;
    end

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Kahn sort over the held edges; fills run_order and empties the store.
    function automatic void kahn_predict();
        int unsigned                n;
        int unsigned                emitted;
        int unsigned                indeg [toe_pkg::MAX_NODES];
        logic [toe_pkg::NODE_W-1:0] ready [$];
        logic [toe_pkg::NODE_W-1:0] node;
        logic [toe_pkg::NODE_W-1:0] to;
        toe_pkg::t_out_item         r;
        n = (node_cnt > toe_pkg::MAX_NODES) ? toe_pkg::MAX_NODES : node_cnt;
        run_order.delete();
        foreach (indeg[v]) indeg[v] = 0;
        for (int unsigned e = 0; e < edges_held; e++) begin
            if (edge_mem[e].from_node < n && edge_mem[e].to_node < n)
                indeg[edge_mem[e].to_node]++;
        end
        for (int unsigned v = 0; v < n; v++) begin
            if (indeg[v] == 0) ready = {ready, toe_pkg::NODE_W'(v)};
        end
        // Successors are released in load order of their edges.
        while (ready.size() != 0) begin
            node = ready.pop_front();
            r = '0;
            r.node_index = node;
            r.node_valid = 1'b1;
            run_order = {run_order, r};
            for (int unsigned e = 0; e < edges_held; e++) begin
                to = edge_mem[e].to_node;
                if (edge_mem[e].from_node == node && to < n && indeg[to] != 0) begin
                    indeg[to]--;
                    if (indeg[to] == 0) ready = {ready, to};
                end
            end
        end
        // The final result carries the run status; an empty run still gets one.
        emitted = run_order.size();
        r = (emitted == 0) ? toe_pkg::t_out_item'('0) : run_order.pop_back();
        r.last          = 1'b1;
        r.cycle_found   = (emitted < n);
        r.edge_overflow = overflow_held;
        run_order = {run_order, r};
        edges_held    = 0;
        overflow_held = 1'b0;
    endfunction

    // Offer one item after a random gap and update the bench state on transfer.
    task automatic send_item(input toe_pkg::t_in_item item, input logic typed,
                             input toe_pkg::t_out_item typed_res);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall !== 1'b0);
        items_sent++;
        if (item.action == toe_pkg::ACT_LOAD) begin
            loads_sent++;
            if (edges_held < toe_pkg::MAX_EDGES) begin
                edge_mem[edges_held] = '{item.edge_source, item.edge_target};
                edges_held++;
            end else begin
                overflow_held = 1'b1;
            end
        end else begin
            runs_sent++;
            kahn_predict();
            if (typed) order_expect_q = {order_expect_q, typed_res};
            else order_expect_q = {order_expect_q, run_order};
        end
    endtask

    // Stop sending, wait for every outstanding node, then let the engine settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (order_expect_q.size() != 0) @(posedge clk);
        repeat (POST_RUN_CYCLES) @(posedge clk);
    endtask

    // APB write of the node count, followed by a read back.
    task automatic set_node_count(input logic [toe_pkg::CNT_W-1:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NODE_COUNT_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        node_cnt = value;
        cfg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("node_count readback", 32'(value), readback);
    endtask

    // Result side: random stall per transfer, then compare with the oldest expectation.
    initial begin : order_checker
        int unsigned        hold;
        toe_pkg::t_out_item got;
        toe_pkg::t_out_item want;
        wait (rst_n === 1'b1);
        forever begin
            hold = calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (out_valid !== 1'b1);
            got = out_data;
            if (order_expect_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                mismatches++;
            end else begin
                want = order_expect_q.pop_front();
                results_checked++;
                check_field("node_index", 32'(want.node_index), 32'(got.node_index));
                check_field("node_valid", 32'(want.node_valid), 32'(got.node_valid));
                check_field("last", 32'(want.last), 32'(got.last));
                check_field("cycle_found", 32'(want.cycle_found), 32'(got.cycle_found));
                check_field("edge_overflow", 32'(want.edge_overflow),
                            32'(got.edge_overflow));
            end
        end
    end

    // Stimulus: reset, directed table, full store, random graphs.
    initial begin : stimulus
        toe_pkg::t_in_item item;
        t_shape            shape;
        int unsigned       rand_items;
        int unsigned       ne;
        int unsigned       n_edges;
        int unsigned       a;
        int unsigned       b;
        int unsigned       pick;
        bit                flip;
        bit                back;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; a count change waits until the engine is idle.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_cnt) begin
                drain_results();
                set_node_count(directed_rows[i].cnt);
            end
            item.action      = directed_rows[i].action;
            item.edge_source = directed_rows[i].src;
            item.edge_target = directed_rows[i].tgt;
            send_item(item, directed_rows[i].typed, directed_rows[i].res);
        end

        // Fill the edge store two past capacity at a node count equal to the table size.
        drain_results();
        set_node_count(toe_pkg::CNT_W'(toe_pkg::MAX_NODES));
        calm = 1'b1;
        for (int unsigned j = 0; j < toe_pkg::MAX_EDGES + 2; j++) begin
            a = $urandom_range(0, toe_pkg::MAX_NODES - 1);
            b = $urandom_range(0, toe_pkg::MAX_NODES - 1);
            if (a == b) b = a ^ 1;
            item = '{toe_pkg::ACT_LOAD, toe_pkg::NODE_W'((a < b) ? a : b),
                     toe_pkg::NODE_W'((a < b) ? b : a)};
            send_item(item, 1'b0, NO_RESULT);
        end
        item = '{toe_pkg::ACT_RUN, toe_pkg::NODE_W'($urandom), toe_pkg::NODE_W'($urandom)};
        send_item(item, 1'b0, NO_RESULT);
        calm = 1'b0;

        // Random graphs, each a burst of edge loads closed by one run.
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                drain_results();
                // Extremes are drawn often; otherwise any count in range.
                pick = $urandom_range(0, 9);
                case (pick)
                    0: set_node_count('0);
                    1: set_node_count('1);
                    2: set_node_count(toe_pkg::CNT_W'($urandom_range(toe_pkg::MAX_NODES + 1,
                                                                      126)));
                    3: set_node_count(toe_pkg::CNT_W'(toe_pkg::MAX_NODES));
                    4: set_node_count(toe_pkg::CNT_W'(1));
                    default: set_node_count(toe_pkg::CNT_W'($urandom_range(2,
                                                              toe_pkg::MAX_NODES)));
                endcase
            end
            ne = (node_cnt == 0) ? 1 :
                 ((node_cnt > toe_pkg::MAX_NODES) ? toe_pkg::MAX_NODES : node_cnt);
            calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            shape = (pick < 6) ? SHAPE_DAG : (pick < 8) ? SHAPE_NOISE :
                    (pick < 9) ? SHAPE_LOOP : SHAPE_BARE;
            n_edges = (shape == SHAPE_BARE) ? 0 : $urandom_range(1, 20);
            flip = $urandom_range(0, 1);
            for (int unsigned j = 0; j < n_edges; j++) begin
                if (shape == SHAPE_NOISE) begin
                    item = '{toe_pkg::ACT_LOAD, toe_pkg::NODE_W'($urandom),
                             toe_pkg::NODE_W'($urandom)};
                end else begin
                    // Edges follow one index direction; a loop graph adds one against it.
                    a = $urandom_range(0, ne - 1);
                    b = $urandom_range(0, ne - 1);
                    if (a == b && ne > 1) b = (a == 0) ? 1 : a - 1;
                    back = (shape == SHAPE_LOOP && j == n_edges / 2);
                    if (flip ^ back)
                        item = '{toe_pkg::ACT_LOAD, toe_pkg::NODE_W'((a > b) ? a : b),
                                 toe_pkg::NODE_W'((a > b) ? b : a)};
                    else
                        item = '{toe_pkg::ACT_LOAD, toe_pkg::NODE_W'((a < b) ? a : b),
                                 toe_pkg::NODE_W'((a < b) ? b : a)};
                end
                send_item(item, 1'b0, NO_RESULT);
                rand_items++;
            end
            item = '{toe_pkg::ACT_RUN, toe_pkg::NODE_W'($urandom), toe_pkg::NODE_W'($urandom)};
            send_item(item, 1'b0, NO_RESULT);
            rand_items++;
            if ($urandom_range(0, 5) == 0) drain_results();
        end

        drain_results();
        $display("Sent %0d items: %0d edge loads and %0d sort runs under %0d node-count writes.",
                 items_sent, loads_sent, runs_sent, cfg_writes);
        $display("Checked %0d results over empty, looped, full-store and random graphs.",
                 results_checked);
        if (mismatches == 0) begin
            $display("tb_topological_order_engine_unit passed");
        end else begin
            $display("tb_topological_order_engine_unit failed");
        end
        $finish;
    end

    // Hard stop in case the engine hangs.
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("tb_topological_order_engine_unit failed");
        $finish;
    end

endmodule
